FILE: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int MAX_BYTES = 4;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_STR     = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX1    = 4'd3,
		PH_HEX2    = 4'd4,
		PH_HEX3    = 4'd5,
		PH_HEX4    = 4'd6,
		PH_PAIR_BS = 4'd7,
		PH_PAIR_U  = 4'd8,
		PH_LOW1    = 4'd9,
		PH_LOW2    = 4'd10,
		PH_LOW3    = 4'd11,
		PH_LOW4    = 4'd12
	} phase_t;

	typedef enum logic [3:0] {
		ST_BUSY      = 4'd0,
		ST_DONE      = 4'd1,
		ST_EXP_QUOTE = 4'd2,
		ST_UNTERM    = 4'd3,
		ST_BAD_ESC   = 4'd4,
		ST_BAD_UNI   = 4'd5,
		ST_BAD_PAIR  = 4'd6,
		ST_LONE_LOW  = 4'd7,
		ST_CTRL      = 4'd8
	} status_t;

	typedef struct packed {
		logic [2:0]                 count;
		logic                       is_status;
		status_t                    status;
		logic [MAX_BYTES-1:0][7:0]  bytes;
	} result_t;

endpackage

FILE: design/jsu_decode.sv
// Escape decoder: parser state and the per-item decode into up to four result bytes.
module jsu_decode
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [15:0] code_q, code_d;
	logic [9:0]  high_q, high_d;

	logic [3:0]  hex_val;
	logic        hex_ok;
	logic [15:0] unit_next;
	logic [20:0] pair_cp;
	logic [20:0] cp;
	logic        emit;

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
		if (end_of_input) begin
			hex_ok = 1'b0;
		end
	end

	assign unit_next = {code_q[11:0], hex_val};
	assign pair_cp = 21'h10000 + {1'b0, high_q, unit_next[9:0]};

	always_comb begin
		phase_d = phase_q;
		code_d = code_q;
		high_d = high_q;
		emit = 1'b0;
		cp = {5'd0, unit_next};
		res = '0;
		res.status = ST_BUSY;

		unique case (phase_q)
			PH_STR: begin
				if (end_of_input) begin
					res.is_status = 1'b1;
					res.status = ST_UNTERM;
				end else if (in_byte == CH_QUOTE) begin
					res.is_status = 1'b1;
					res.status = ST_DONE;
				end else if (in_byte == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else if (in_byte < CH_SPACE) begin
					res.is_status = 1'b1;
					res.status = ST_CTRL;
				end else begin
					res.count = 3'd1;
					res.bytes[0] = in_byte;
				end
			end
			PH_ESC: begin
				res.count = 3'd1;
				phase_d = PH_STR;
				if (end_of_input) begin
					res.is_status = 1'b1;
					res.status = ST_BAD_ESC;
				end else begin
					unique case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = in_byte;
						CH_LOW_B: res.bytes[0] = 8'h08;
						CH_LOW_F: res.bytes[0] = 8'h0C;
						CH_LOW_N: res.bytes[0] = 8'h0A;
						CH_LOW_R: res.bytes[0] = 8'h0D;
						CH_LOW_T: res.bytes[0] = 8'h09;
						CH_LOW_U: begin
							res.count = 3'd0;
							code_d = 16'd0;
							phase_d = PH_HEX1;
						end
						default: begin
							res.is_status = 1'b1;
							res.status = ST_BAD_ESC;
						end
					endcase
				end
			end
			PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
				if (!hex_ok) begin
					res.is_status = 1'b1;
					res.status = ST_BAD_UNI;
				end else begin
					code_d = unit_next;
					if (phase_q != PH_HEX4) begin
						phase_d = phase_t'(phase_q + 4'd1);
					end else if (unit_next[15:10] == 6'b110110) begin
						high_d = unit_next[9:0];
						phase_d = PH_PAIR_BS;
					end else if (unit_next[15:10] == 6'b110111) begin
						res.is_status = 1'b1;
						res.status = ST_LONE_LOW;
					end else begin
						emit = 1'b1;
						phase_d = PH_STR;
					end
				end
			end
			PH_PAIR_BS: begin
				if (end_of_input || in_byte != CH_BSLASH) begin
					res.is_status = 1'b1;
					res.status = ST_BAD_PAIR;
				end else begin
					phase_d = PH_PAIR_U;
				end
			end
			PH_PAIR_U: begin
				if (end_of_input || in_byte != CH_LOW_U) begin
					res.is_status = 1'b1;
					res.status = ST_BAD_PAIR;
				end else begin
					code_d = 16'd0;
					phase_d = PH_LOW1;
				end
			end
			PH_LOW1, PH_LOW2, PH_LOW3, PH_LOW4: begin
				if (!hex_ok) begin
					res.is_status = 1'b1;
					res.status = ST_BAD_PAIR;
				end else begin
					code_d = unit_next;
					if (phase_q != PH_LOW4) begin
						phase_d = phase_t'(phase_q + 4'd1);
					end else if (unit_next[15:10] == 6'b110111) begin
						emit = 1'b1;
						cp = pair_cp;
						phase_d = PH_STR;
					end else begin
						res.is_status = 1'b1;
						res.status = ST_BAD_PAIR;
					end
				end
			end
			default: begin
				if (end_of_input || in_byte != CH_QUOTE) begin
					res.is_status = 1'b1;
					res.status = ST_EXP_QUOTE;
				end else begin
					phase_d = PH_STR;
				end
			end
		endcase

		if (emit) begin
			if (cp <= 21'h7F) begin
				res.count = 3'd1;
				res.bytes[0] = cp[7:0];
			end else if (cp <= 21'h7FF) begin
				res.count = 3'd2;
				res.bytes[0] = {3'b110, cp[10:6]};
				res.bytes[1] = {2'b10, cp[5:0]};
			end else if (cp <= 21'hFFFF) begin
				res.count = 3'd3;
				res.bytes[0] = {4'b1110, cp[15:12]};
				res.bytes[1] = {2'b10, cp[11:6]};
				res.bytes[2] = {2'b10, cp[5:0]};
			end else begin
				res.count = 3'd4;
				res.bytes[0] = {5'b11110, cp[20:18]};
				res.bytes[1] = {2'b10, cp[17:12]};
				res.bytes[2] = {2'b10, cp[11:6]};
				res.bytes[3] = {2'b10, cp[5:0]};
			end
		end

		if (res.is_status) begin
			res.count = 3'd1;
			res.bytes = '0;
			phase_d = PH_IDLE;
			code_d = 16'd0;
			high_d = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			code_q <= 16'd0;
			high_q <= 10'd0;
		end else if (commit) begin
			phase_q <= phase_d;
			code_q <= code_d;
			high_q <= high_d;
		end
	end

endmodule

FILE: design/jsu_result_buf.sv
// Result register: holds the results of one item and hands them out one per cycle while m_axis_tready is high.
module jsu_result_buf
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	output logic [4:0]  m_axis_tuser
);

	logic [2:0]                cnt_q;
	logic [1:0]                idx_q;
	logic                      is_status_q;
	status_t                   status_q;
	logic [MAX_BYTES-1:0][7:0] bytes_q;
	logic                      take;

	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tlast = (({1'b0, idx_q} + 3'd1) == cnt_q);
	assign m_axis_tdata = bytes_q[idx_q];
	assign m_axis_tuser = {status_q, !is_status_q};
	assign take = m_axis_tvalid && m_axis_tready;
	assign free = (cnt_q == 3'd0) || (take && m_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
			is_status_q <= 1'b0;
			status_q <= ST_BUSY;
		end else if (load && res.count != 3'd0) begin
			cnt_q <= res.count;
			idx_q <= 2'd0;
			is_status_q <= res.is_status;
			status_q <= res.status;
		end else if (take) begin
			if (m_axis_tlast) begin
				cnt_q <= 3'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.count != 3'd0) begin
			bytes_q <= res.bytes;
		end
	end

endmodule

FILE: design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Channel   Dir  Carries
// s_axis    in   tdata = in_byte[7:0]; tlast = end_of_input
// m_axis    out  tdata = out_byte[7:0]; tuser = out_valid, status[3:0]; tlast = last
//
// An item is held in the input register, is decoded and loaded into the
// result register, and its results leave one per cycle unless m_axis_tready is low.
// An item producing one result or none is taken every cycle unless the output stalls;
// one producing two to four UTF-8 bytes holds the input until its last byte is taken.
// Reset returns the parser to waiting for an opening quote and empties both registers.
// A stall on the output holds the input register full and lowers s_axis_tready.
module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
	input  logic        s_axis_tlast,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
	output logic        m_axis_tlast,   // last
	output logic [4:0]  m_axis_tuser    // out_valid, status[3:0]
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       free;
	logic       advance;
	result_t    res;

	assign advance = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1 <= s_axis_tlast;
		end
	end

	jsu_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (advance),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.res          (res)
	);

	jsu_result_buf u_result_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: tb/json_string_unescape_utf8_tb.sv
// Self-checking testbench for the JSON string unescaper: random and directed text, UTF-8 checks.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       eoi;
		logic       hold;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		status_t    status;
		logic       last;
	} utf8_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [4:0] m_axis_tuser;

	text_item_t   text_items[$];
	utf8_result_t utf8_expected[$];
	utf8_result_t step_results[$];
	logic         hold_next = 1'b0;
	int           items_total = 0;
	int           items_taken = 0;
	int           idle_mode = 0;
	int           mismatches = 0;

	phase_t      str_phase = PH_IDLE;
	logic [15:0] unit_acc = 16'h0000;
	logic [9:0]  high_half = 10'h000;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
		return 5'h10;
	endfunction

	task automatic push_result(input logic [7:0] data, input logic valid, input status_t st);
		utf8_result_t r;
		r.data = data;
		r.valid = valid;
		r.status = st;
		r.last = 1'b0;
		step_results.insert(step_results.size(), r);
	endtask

	task automatic end_string(input status_t st);
		push_result(8'h00, 1'b0, st);
		str_phase = PH_IDLE;
		unit_acc = 16'h0000;
		high_half = 10'h000;
	endtask

	task automatic push_code_point(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_result(cp[7:0], 1'b1, ST_BUSY);
		end else if (cp <= 21'h7FF) begin
			push_result(8'hC0 | 8'(cp >> 6), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[5:0]), 1'b1, ST_BUSY);
		end else if (cp <= 21'hFFFF) begin
			push_result(8'hE0 | 8'(cp >> 12), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[11:6]), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[5:0]), 1'b1, ST_BUSY);
		end else begin
			push_result(8'hF0 | 8'(cp[20:18]), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[17:12]), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[11:6]), 1'b1, ST_BUSY);
			push_result(8'h80 | 8'(cp[5:0]), 1'b1, ST_BUSY);
		end
	endtask

	// Advances the decoder by one accepted item and queues the UTF-8 bytes or status it yields.
	task automatic unescape_step(input logic [7:0] b, input logic eoi);
		logic [4:0]   d;
		logic [15:0]  cu;
		logic [20:0]  cp;
		utf8_result_t r;
		step_results.delete();
		d = eoi ? 5'h10 : hex_nibble(b);
		cu = {unit_acc[11:0], d[3:0]};
		if (str_phase == PH_IDLE) begin
			if (eoi || b != CH_QUOTE) end_string(ST_EXP_QUOTE);
			else str_phase = PH_STR;
		end else if (str_phase == PH_STR) begin
			if (eoi) end_string(ST_UNTERM);
			else if (b == CH_QUOTE) end_string(ST_DONE);
			else if (b == CH_BSLASH) str_phase = PH_ESC;
			else if (b < CH_SPACE) end_string(ST_CTRL);
			else push_result(b, 1'b1, ST_BUSY);
		end else if (str_phase == PH_ESC) begin
			str_phase = PH_STR;
			if (eoi) begin
				end_string(ST_BAD_ESC);
			end else begin
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(b, 1'b1, ST_BUSY);
					CH_LOW_B: push_result(8'h08, 1'b1, ST_BUSY);
					CH_LOW_F: push_result(8'h0C, 1'b1, ST_BUSY);
					CH_LOW_N: push_result(8'h0A, 1'b1, ST_BUSY);
					CH_LOW_R: push_result(8'h0D, 1'b1, ST_BUSY);
					CH_LOW_T: push_result(8'h09, 1'b1, ST_BUSY);
					CH_LOW_U: begin
						unit_acc = 16'h0000;
						str_phase = PH_HEX1;
					end
					default: end_string(ST_BAD_ESC);
				endcase
			end
		end else if (str_phase >= PH_HEX1 && str_phase <= PH_HEX4) begin
			if (d[4]) begin
				end_string(ST_BAD_UNI);
			end else begin
				unit_acc = cu;
				if (str_phase != PH_HEX4) begin
					str_phase = phase_t'(str_phase + 4'd1);
				end else if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
					high_half = cu[9:0];
					str_phase = PH_PAIR_BS;
				end else if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
					end_string(ST_LONE_LOW);
				end else begin
					push_code_point({5'd0, cu});
					str_phase = PH_STR;
				end
			end
		end else if (str_phase == PH_PAIR_BS) begin
			if (eoi || b != CH_BSLASH) end_string(ST_BAD_PAIR);
			else str_phase = PH_PAIR_U;
		end else if (str_phase == PH_PAIR_U) begin
			if (eoi || b != CH_LOW_U) begin
				end_string(ST_BAD_PAIR);
			end else begin
				unit_acc = 16'h0000;
				str_phase = PH_LOW1;
			end
		end else begin
			if (d[4]) begin
				end_string(ST_BAD_PAIR);
			end else begin
				unit_acc = cu;
				if (str_phase != PH_LOW4) begin
					str_phase = phase_t'(str_phase + 4'd1);
				end else if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
					cp = 21'h10000 + {1'b0, high_half, 10'd0} + 21'(cu - 16'hDC00);
					push_code_point(cp);
					str_phase = PH_STR;
				end else begin
					end_string(ST_BAD_PAIR);
				end
			end
		end
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.insert(step_results.size(), r);
		end
		foreach (step_results[i]) utf8_expected.insert(utf8_expected.size(), step_results[i]);
	endtask

	task automatic put_item(input logic [7:0] b, input logic eoi);
		text_item_t t;
		t.b = b;
		t.eoi = eoi;
		t.hold = hold_next;
		hold_next = 1'b0;
		text_items.insert(text_items.size(), t);
	endtask

	task automatic put_byte(input logic [7:0] b);
		put_item(b, 1'b0);
	endtask

	task automatic put_eoi();
		put_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	task automatic put_escape_u(input logic [15:0] v);
		put_byte(CH_BSLASH);
		put_byte(CH_LOW_U);
		for (int i = 3; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
	endtask

	// Zero to three valid hex digits, then a non-hex byte or the end of the text.
	task automatic put_bad_digit();
		logic [7:0] b;
		int         k;
		k = $urandom_range(0, 3);
		for (int i = 0; i < k; i++) put_byte(hex_char(4'($urandom_range(0, 15))));
		if ($urandom_range(0, 3) == 0) begin
			put_eoi();
		end else begin
			do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) != 5'h10);
			put_byte(b);
		end
	endtask

	task automatic put_random_string();
		logic [7:0]  b;
		logic [15:0] v;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [9:0]  hs;
		int          nseg;
		if ($urandom_range(0, 19) == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				put_eoi();
			end else begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
				put_byte(b);
			end
			return;
		end
		put_byte(CH_QUOTE);
		nseg = $urandom_range(0, 6);
		for (int i = 0; i < nseg; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
					put_byte(b);
				end
				4, 5: begin
					put_byte(CH_BSLASH);
					case ($urandom_range(0, 7))
						0: put_byte(CH_QUOTE);
						1: put_byte(CH_BSLASH);
						2: put_byte(CH_SLASH);
						3: put_byte(CH_LOW_B);
						4: put_byte(CH_LOW_F);
						5: put_byte(CH_LOW_N);
						6: put_byte(CH_LOW_R);
						default: put_byte(CH_LOW_T);
					endcase
				end
				6, 7: begin
					case ($urandom_range(0, 2))
						0: begin
							lo = 16'h0000;
							hi = 16'h007F;
						end
						1: begin
							lo = 16'h0080;
							hi = 16'h07FF;
						end
						default: begin
							lo = 16'h0800;
							hi = 16'hFFFF;
						end
					endcase
					if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 1) ? hi : lo;
					else v = 16'($urandom_range(lo, hi));
					if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
					put_escape_u(v);
				end
				default: begin
					hs = ($urandom_range(0, 3) == 0) ? {10{1'($urandom_range(0, 1))}}
						: 10'($urandom_range(0, 1023));
					put_escape_u(16'hD800 | 16'(hs));
					hs = ($urandom_range(0, 3) == 0) ? {10{1'($urandom_range(0, 1))}}
						: 10'($urandom_range(0, 1023));
					put_escape_u(16'hDC00 | 16'(hs));
				end
			endcase
		end
		if ($urandom_range(0, 99) < 70) begin
			put_byte(CH_QUOTE);
			return;
		end
		case ($urandom_range(0, 7))
			0: put_eoi();
			1: put_byte(8'($urandom_range(0, 31)));
			2: begin
				put_byte(CH_BSLASH);
				do b = 8'($urandom_range(0, 255));
				while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
					CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U});
				put_byte(b);
			end
			3: begin
				put_byte(CH_BSLASH);
				put_eoi();
			end
			4: begin
				put_byte(CH_BSLASH);
				put_byte(CH_LOW_U);
				put_bad_digit();
			end
			5: put_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
			default: begin
				put_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
				case ($urandom_range(0, 5))
					0: begin
						do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
						put_byte(b);
					end
					1: put_eoi();
					2: begin
						put_byte(CH_BSLASH);
						do b = 8'($urandom_range(0, 255)); while (b == CH_LOW_U);
						put_byte(b);
					end
					3: begin
						put_byte(CH_BSLASH);
						put_eoi();
					end
					4: begin
						put_byte(CH_BSLASH);
						put_byte(CH_LOW_U);
						put_bad_digit();
					end
					default: begin
						do v = 16'($urandom_range(0, 65535));
						while (v >= 16'hDC00 && v <= 16'hDFFF);
						put_escape_u(v);
					end
				endcase
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : text_driver
		logic busy;
		logic offer;
		int   idle_pct;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
		end else begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				unescape_step(s_axis_tdata, s_axis_tlast);
				void'(text_items.pop_front());
				items_taken = items_taken + 1;
				busy = 1'b0;
			end
			if (items_taken < items_total / 3) begin
				idle_mode <= 0;
				idle_pct = 38;
			end else if (items_taken < 2 * items_total / 3) begin
				idle_mode <= 1;
				idle_pct = 88;
			end else begin
				idle_mode <= 2;
				idle_pct = 0;
			end
			if (!busy) begin
				offer = text_items.size() > 0
					&& !(text_items[0].hold && utf8_expected.size() != 0)
					&& $urandom_range(0, 99) >= idle_pct;
				if (offer) begin
					s_axis_tdata <= text_items[0].b;
					s_axis_tlast <= text_items[0].eoi;
				end
				s_axis_tvalid <= offer;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : utf8_monitor
		utf8_result_t want;
		int           stall_pct;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (utf8_expected.size() == 0) begin
					mismatches++;
					$display("%0t: expected none, got byte %h flags %b last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = utf8_expected.pop_front();
					if (m_axis_tdata !== want.data || m_axis_tuser[0] !== want.valid
						|| m_axis_tuser[4:1] !== want.status || m_axis_tlast !== want.last) begin
						mismatches++;
						$display("%0t: expected %h/%b/%0d/%b, got %h/%b/%0d/%b",
							$time, want.data, want.valid, want.status, want.last,
							m_axis_tdata, m_axis_tuser[0], m_axis_tuser[4:1], m_axis_tlast);
					end
				end
			end
			case (idle_mode)
				0: stall_pct = 88;
				1: stall_pct = 38;
				default: stall_pct = 0;
			endcase
			m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	initial begin
		int n_strings;
		put_byte(8'h00);
		put_eoi();
		put_byte(CH_QUOTE);
		put_byte(8'hFF);
		put_byte(CH_BSLASH);
		put_byte(CH_LOW_T);
		put_byte(CH_BSLASH);
		put_byte(CH_LOW_U);
		put_byte(8'h46);
		put_byte(8'h66);
		put_byte(8'h46);
		put_byte(8'h66);
		put_byte(CH_QUOTE);
		put_byte(CH_QUOTE);
		put_byte(8'h1F);
		put_byte(CH_QUOTE);
		put_eoi();
		put_byte(CH_QUOTE);
		put_byte(CH_BSLASH);
		put_byte(8'h71);
		put_byte(CH_QUOTE);
		put_byte(CH_BSLASH);
		put_byte(CH_LOW_U);
		put_byte(8'h67);
		n_strings = 0;
		while (text_items.size() < 470) begin
			// Now and then a string waits until every pending result has drained.
			hold_next = (n_strings % 40 == 10);
			put_random_string();
			n_strings++;
		end
		items_total = text_items.size();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (items_taken < items_total) @(posedge clk);
		while (utf8_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
